### rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, constants and helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

    // Character constants
    localparam logic [7:0] PCT_CHAR  = 8'h25;
    localparam int unsigned HEX_RADIX = 16;

    // Configuration defaults and register map
    localparam logic [15:0] CAP_RESET       = 16'd256;
    localparam logic        REG_OUT_CAPACITY = 1'b0;
    localparam int unsigned QUEUE_DEPTH     = 4;

    // One decoded request from the front: up to three data bytes, then maybe
    // the end marker.
    typedef struct packed {
        logic [1:0]      cnt;
        logic            last;
        logic [2:0][7:0] data;
    } req_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h41 + 8'd10;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h61 + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

### rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder with a bounded output per string.
// ----------------------------------------------------------------------------
// The first result of an accepted byte is registered in the request queue,
// then in the output register; its further results follow one per cycle
// unless out_stall holds them. Throughput: one byte per cycle unless in_stall;
// dropped results take back-side steps too; a four-entry queue absorbs bursts.
// Reset: rst_n clears escape state, queue, counters and output valid at once;
// out_capacity returns to 256.
// ----------------------------------------------------------------------------
module url_percent_decoder import upd_pkg::*;
#(
    parameter int unsigned Q_DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  src_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_end
);

    logic [15:0] cap_reg;
    logic        q_push, q_pop, q_full, q_nonempty;
    req_t        q_req, q_head;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUT_CAPACITY) ? {16'h0000, cap_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_OUT_CAPACITY)
        begin
            cap_reg <= pwdata[15:0];
        end
    end

    // Front: accept and classify
    upd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .src_byte (src_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_req    (q_req)
    );

    // Request queue
    upd_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_req (q_req),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    // Back: emit results
    upd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .out_capacity (cap_reg),
        .q_nonempty   (q_nonempty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .out_end      (out_end)
    );

endmodule

### rtl/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front
// Accepts source bytes, tracks the escape state and turns each byte into a
// request of literal or decoded bytes plus an optional end marker.
// ----------------------------------------------------------------------------
module upd_front import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] src_byte,
    input  logic       q_full,
    output logic       q_push,
    output req_t       q_req
);

    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_PCT  = 2'd1;
    localparam logic [1:0] PEND_HEX  = 2'd2;

    logic [1:0] pend_reg, pend_next;
    logic [7:0] held_reg, held_next;
    logic       accept;
    req_t       req;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Classify the byte against the pending escape
    always_comb
    begin
        pend_next = pend_reg;
        held_next = held_reg;
        req       = '0;
        if (src_byte == 8'h00)
        begin
            req.last = 1'b1;
            req.data[0] = PCT_CHAR;
            req.data[1] = held_reg;
            if (pend_reg == PEND_PCT)
            begin
                req.cnt = 2'd1;
            end
            else if (pend_reg == PEND_HEX)
            begin
                req.cnt = 2'd2;
            end
            pend_next = PEND_NONE;
            held_next = 8'h00;
        end
        else
        begin
            unique case (pend_reg)
                PEND_PCT:
                begin
                    if (is_hex(src_byte))
                    begin
                        held_next = src_byte;
                        pend_next = PEND_HEX;
                    end
                    else
                    begin
                        req.data[0] = PCT_CHAR;
                        req.data[1] = src_byte;
                        if (src_byte == PCT_CHAR)
                        begin
                            req.cnt   = 2'd1;
                            pend_next = PEND_PCT;
                        end
                        else
                        begin
                            req.cnt   = 2'd2;
                            pend_next = PEND_NONE;
                        end
                    end
                end
                PEND_HEX:
                begin
                    held_next = 8'h00;
                    if (is_hex(src_byte))
                    begin
                        req.cnt     = 2'd1;
                        req.data[0] = {hex_val(held_reg), hex_val(src_byte)};
                        pend_next   = PEND_NONE;
                    end
                    else
                    begin
                        req.data[0] = PCT_CHAR;
                        req.data[1] = held_reg;
                        req.data[2] = src_byte;
                        if (src_byte == PCT_CHAR)
                        begin
                            req.cnt   = 2'd2;
                            pend_next = PEND_PCT;
                        end
                        else
                        begin
                            req.cnt   = 2'd3;
                            pend_next = PEND_NONE;
                        end
                    end
                end
                default:
                begin
                    if (src_byte == PCT_CHAR)
                    begin
                        pend_next = PEND_PCT;
                    end
                    else
                    begin
                        req.cnt     = 2'd1;
                        req.data[0] = src_byte;
                        pend_next   = PEND_NONE;
                    end
                end
            endcase
        end
    end

    // Push only requests that carry something
    assign q_push = accept && (req.cnt != 2'd0 || req.last);
    assign q_req  = req;

    // Advance escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            held_reg <= 8'h00;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            held_reg <= held_next;
        end
    end

`ifndef SYNTHESIS
    a_pend_legal: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("front: illegal pending count");

    a_held_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg != PEND_HEX) |-> (held_reg == 8'h00))
        else $error("front: held digit not cleared");
`endif

endmodule

### rtl/upd_queue.sv
// ----------------------------------------------------------------------------
// upd_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module upd_queue import upd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  req_t push_req,
    input  logic pop,
    output logic full,
    output logic nonempty,
    output req_t head
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    req_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] count_reg;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem_reg[rd_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_req;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue: count overflow");
`endif

endmodule

### rtl/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back
// Walks each queued request one result per cycle while the output is not
// stalled, applies the capacity limit and drives the output register.
// ----------------------------------------------------------------------------
module upd_back import upd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] out_capacity,
    input  logic        q_nonempty,
    input  req_t        q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_end
);

    logic [1:0]  idx_reg;
    logic [15:0] emitted_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;

    logic        step;
    logic        is_end;
    logic        room;
    logic        emit;
    logic [1:0]  last_idx;
    logic [7:0]  cur_byte;

    // Select the current element of the head request
    assign step     = q_nonempty && (!out_valid_reg || !out_stall);
    assign is_end   = q_head.last && (idx_reg == q_head.cnt);
    assign last_idx = q_head.last ? q_head.cnt : q_head.cnt - 2'd1;
    assign room     = (out_capacity != 16'd0) &&
                      (({1'b0, emitted_reg} + 17'd1) < {1'b0, out_capacity});
    assign emit     = is_end ? (out_capacity != 16'd0) : room;
    assign cur_byte = is_end ? 8'h00 : q_head.data[idx_reg];
    assign q_pop    = step && (idx_reg == last_idx);

    // Advance element index and emitted count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= 2'd0;
            emitted_reg <= 16'd0;
        end
        else if (step)
        begin
            idx_reg <= (idx_reg == last_idx) ? 2'd0 : idx_reg + 2'd1;
            if (is_end)
            begin
                emitted_reg <= 16'd0;
            end
            else if (room)
            begin
                emitted_reg <= emitted_reg + 16'd1;
            end
        end
    end

    // Hold or load the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_byte_reg <= cur_byte;
            out_end_reg  <= is_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_end   = out_end_reg;

`ifndef SYNTHESIS
    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> (out_byte_reg == 8'h00))
        else $error("back: end result carries data");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_nonempty |-> (idx_reg <= last_idx))
        else $error("back: element index past request");
`endif

endmodule
